@@ hw/rtl/zvn_pkg.sv @@
// Shared constants, widths and the sequencer state type of the z-score normalizer.
// No dependencies; every other file of the block imports this package.
package zvn_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int SAMPLE_W     = 32;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int FRAC_W       = 16;

  // Datapath widths for signed 32-bit samples and up to 64 elements
  localparam int SUM_W   = 40;             // running sum and d = n*x - S
  localparam int MAG_W   = SUM_W - 1;      // |d|
  localparam int MUL_W   = 32;             // shared multiplier operand width
  localparam int PROD_W  = 2 * MUL_W;
  localparam int HI_W    = MAG_W - MUL_W;  // upper slice of |d|
  localparam int Q_W     = 84;             // sum of squared deviations
  localparam int SD_W    = Q_W / 2;        // n * stddev
  localparam int NUM_W   = 56;             // |d| * 2^16 + sdn / 2
  localparam int ITER_W  = 7;              // divider step count

  localparam logic [SAMPLE_W-1:0] POS_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] NEG_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RD,
    ST_NX,
    ST_D,
    ST_ABS,
    ST_LL,
    ST_LH,
    ST_HH,
    ST_ACC,
    ST_QDIV,
    ST_QWAIT,
    ST_SQRT,
    ST_SWAIT,
    ST_DGO,
    ST_DWAIT,
    ST_EMIT
  } zvn_state_t;

endpackage

@@ hw/rtl/zvn_if.sv @@
// Valid/ready channel interfaces for samples in and normalized results out.
// Depends on zvn_pkg for the sample width.
interface zvn_in_if import zvn_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_value;
  logic                last_sample;

  modport source (output valid, output sample_value, output last_sample, input ready);
  modport sink   (input valid, input sample_value, input last_sample, output ready);
endinterface

interface zvn_out_if import zvn_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] normalized_value;
  logic                flat_vector;
  logic                saturated;
  logic                last_result;

  modport source (output valid, output normalized_value, output flat_vector,
                  output saturated, output last_result, input ready);
  modport sink   (input valid, input normalized_value, input flat_vector,
                  input saturated, input last_result, output ready);
endinterface

@@ hw/rtl/zvn_mul.sv @@
// Shared unsigned 32x32 multiplier with a registered product.
// Depends on zvn_pkg for operand widths.
module zvn_mul import zvn_pkg::*; (
  input  logic              clk,
  input  logic [MUL_W-1:0]  op_a,
  input  logic [MUL_W-1:0]  op_b,
  output logic [PROD_W-1:0] prod
);

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end

  assign prod = prod_r;

endmodule

@@ hw/rtl/zvn_div.sv @@
// Restoring shift-subtract divider, one quotient bit per cycle.
// Numerator is taken from the top; iters sets how many bits are consumed.
// Depends on zvn_pkg for widths.
module zvn_div import zvn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [Q_W-1:0]    num,
  input  logic [SD_W-1:0]   den,
  input  logic [ITER_W-1:0] iters,
  output logic              busy,
  output logic [Q_W-1:0]    quo
);

  logic [Q_W-1:0]    num_r;
  logic [SD_W-1:0]   den_r;
  logic [SD_W-1:0]   rem_r;
  logic [Q_W-1:0]    quo_r;
  logic [ITER_W-1:0] cnt_r;
  logic              busy_r;

  logic [SD_W:0] trial;
  logic [SD_W:0] diff;
  logic          fits;

  always_comb begin
    trial = {rem_r, num_r[Q_W-1]};
    diff  = trial - {1'b0, den_r};
    fits  = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= iters;
    end else if (busy_r) begin
      cnt_r <= cnt_r - ITER_W'(1);
      if (cnt_r == ITER_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[Q_W-2:0], 1'b0};
      rem_r <= fits ? diff[SD_W-1:0] : trial[SD_W-1:0];
      quo_r <= {quo_r[Q_W-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

@@ hw/rtl/zvn_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle (floor result).
// Depends on zvn_pkg for widths.
module zvn_sqrt import zvn_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [Q_W-1:0]  rad,
  output logic            busy,
  output logic [SD_W-1:0] root
);

  localparam int R_W = SD_W + 3;

  logic [Q_W-1:0]    rad_r;
  logic [R_W-1:0]    rem_r;
  logic [SD_W-1:0]   root_r;
  logic [ITER_W-1:0] cnt_r;
  logic              busy_r;

  logic [R_W-1:0] cur;
  logic [R_W-1:0] trial;
  logic           ge;

  always_comb begin
    cur   = {rem_r[R_W-3:0], rad_r[Q_W-1 -: 2]};
    trial = R_W'({root_r, 2'b01});
    ge    = cur >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= ITER_W'(SD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - ITER_W'(1);
      if (cnt_r == ITER_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[Q_W-3:0], 2'b00};
      rem_r  <= ge ? (cur - trial) : cur;
      root_r <= {root_r[SD_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

@@ hw/rtl/zscore_vector_normalizer_core.sv @@
// Z-score vector normalizer: top level with sequencer, element store and output register.
// Depends on zvn_pkg, zvn_if, zvn_mul, zvn_div and zvn_sqrt.
//
// Usage:
//   in_ch  (valid/ready) carries one Q16.16 sample per item; last_sample closes the vector.
//   out_ch (valid/ready) returns one normalized item per stored sample, in arrival order,
//   with last_result on the final one, flat_vector when the deviation is zero and
//   saturated when the value was clipped to the Q16.16 range.
//   Up to 64 samples are stored; later samples of the same vector are dropped, but a
//   dropped sample with the last mark still closes the vector.
// Sequence (n = stored elements):
//   - loading accepts one sample per cycle; in_ch.ready is high only while loading.
//   - variance pass, per element: read, n*x, deviation, magnitude, and three
//     partial squares through the shared 32x32 multiplier.
//   - the sum of squares is divided by n on the serial divider, then its square root
//     is taken; each result then goes through a 56-step divide, skipped when flat.
// Reset (rst_n low, synchronous) empties the vector and drops any pending result.
// A stalled receiver holds the current result in the output register; the sequencer
// keeps working on the next element and waits only when that one is ready to leave.
module zscore_vector_normalizer_core import zvn_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  zvn_in_if.sink           in_ch,
  zvn_out_if.source        out_ch
);

  zvn_state_t state_r, state_nxt;

  // element store, undefined until written
  logic [SAMPLE_W-1:0] mem [MAX_ELEMENTS];
  logic [SAMPLE_W-1:0] mem_q_r;

  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  n_r;
  logic [CNT_W-1:0]  idx_r;
  logic              pass2_r;
  logic              x_neg_r;
  logic [SUM_W-1:0]  d_r;
  logic [MAG_W-1:0]  mag_r;
  logic              d_neg_r;
  logic [Q_W-1:0]    acc_r;
  logic [SD_W-1:0]   sdn_r;

  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_val_r;
  logic                out_flat_r;
  logic                out_sat_r;
  logic                out_last_r;

  // shared units
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_prod;
  logic              div_start, div_busy;
  logic [Q_W-1:0]    div_num, div_quo;
  logic [SD_W-1:0]   div_den;
  logic [ITER_W-1:0] div_iters;
  logic              sqrt_start, sqrt_busy;
  logic [SD_W-1:0]   sqrt_root;

  logic              in_acc;
  logic              store_ok;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  idx_inc;
  logic              last_idx;
  logic              out_free;
  logic              emit_load;
  logic [SAMPLE_W-1:0] x_abs;
  logic [SUM_W-1:0]  nx;
  logic [NUM_W-1:0]  q_num;
  logic [NUM_W-1:0]  q_res;
  logic              sdn_zero;
  logic [SAMPLE_W-1:0] emit_val;
  logic              emit_sat;

  zvn_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_prod)
  );

  zvn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .iters (div_iters),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // root of (sum of squares) / n, taken from the held divider quotient
  zvn_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (div_quo),
    .busy  (sqrt_busy),
    .root  (sqrt_root)
  );

  // Handshake and shared helpers
  assign in_ch.ready = (state_r == ST_LOAD);
  assign in_acc      = in_ch.valid && (state_r == ST_LOAD);
  assign store_ok    = cnt_r < CNT_W'(MAX_ELEMENTS);
  assign cnt_inc     = cnt_r + CNT_W'(1);
  assign idx_inc     = idx_r + CNT_W'(1);
  assign last_idx    = (idx_inc == n_r);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign emit_load   = (state_r == ST_EMIT) && out_free;
  assign sdn_zero    = (sdn_r == '0);

  assign x_abs = mem_q_r[SAMPLE_W-1] ? (SAMPLE_W'(0) - mem_q_r) : mem_q_r;
  assign nx    = x_neg_r ? (SUM_W'(0) - mul_prod[SUM_W-1:0]) : mul_prod[SUM_W-1:0];
  assign q_num = NUM_W'({mag_r, {FRAC_W{1'b0}}}) + NUM_W'(sdn_r >> 1);
  assign q_res = div_quo[NUM_W-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:  if (in_acc && in_ch.last_sample) state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_NX;
      ST_NX:    state_nxt = ST_D;
      ST_D:     state_nxt = ST_ABS;
      ST_ABS: begin
        if (!pass2_r) begin
          state_nxt = ST_LL;
        end else if (sdn_zero) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_DGO;
        end
      end
      ST_LL:    state_nxt = ST_LH;
      ST_LH:    state_nxt = ST_HH;
      ST_HH:    state_nxt = ST_ACC;
      ST_ACC:   state_nxt = last_idx ? ST_QDIV : ST_RD;
      ST_QDIV:  state_nxt = ST_QWAIT;
      ST_QWAIT: if (!div_busy) state_nxt = ST_SQRT;
      ST_SQRT:  state_nxt = ST_SWAIT;
      ST_SWAIT: if (!sqrt_busy) state_nxt = ST_RD;
      ST_DGO:   state_nxt = ST_DWAIT;
      ST_DWAIT: if (!div_busy) state_nxt = ST_EMIT;
      ST_EMIT:  if (out_free) state_nxt = last_idx ? ST_LOAD : ST_RD;
      default:  state_nxt = ST_LOAD;
    endcase
  end

  // Unit controls: route operands to the shared multiplier and divider, and start the square root
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_num    = {q_num, {(Q_W-NUM_W){1'b0}}};
    div_den    = sdn_r;
    div_iters  = ITER_W'(NUM_W);
    sqrt_start = 1'b0;
    case (state_r)
      ST_NX: begin
        mul_a = x_abs;
        mul_b = MUL_W'(n_r);
      end
      ST_LL: begin
        mul_a = mag_r[MUL_W-1:0];
        mul_b = mag_r[MUL_W-1:0];
      end
      ST_LH: begin
        mul_a = MUL_W'(mag_r[MAG_W-1:MUL_W]);
        mul_b = mag_r[MUL_W-1:0];
      end
      ST_HH: begin
        mul_a = MUL_W'(mag_r[MAG_W-1:MUL_W]);
        mul_b = MUL_W'(mag_r[MAG_W-1:MUL_W]);
      end
      ST_QDIV: begin
        div_start = 1'b1;
        div_num   = acc_r;
        div_den   = SD_W'(n_r);
        div_iters = ITER_W'(Q_W);
      end
      ST_SQRT: sqrt_start = 1'b1;
      ST_DGO:  div_start  = 1'b1;
      default: ;
    endcase
  end

  // Round-to-nearest quotient to signed Q16.16 with clipping; zero when the vector is flat
  always_comb begin
    emit_val = '0;
    emit_sat = 1'b0;
    if (!sdn_zero) begin
      if (!d_neg_r) begin
        if (|q_res[NUM_W-1:SAMPLE_W-1]) begin
          emit_val = POS_MAX;
          emit_sat = 1'b1;
        end else begin
          emit_val = q_res[SAMPLE_W-1:0];
        end
      end else begin
        if ((|q_res[NUM_W-1:SAMPLE_W]) ||
            (q_res[SAMPLE_W-1] && (|q_res[SAMPLE_W-2:0]))) begin
          emit_val = NEG_MIN;
          emit_sat = 1'b1;
        end else begin
          emit_val = SAMPLE_W'(0) - q_res[SAMPLE_W-1:0];
        end
      end
    end
  end

  // Element store: one write port while loading, one registered read at the element index
  always_ff @(posedge clk) begin
    if (in_acc && store_ok) begin
      mem[cnt_r[ADDR_W-1:0]] <= in_ch.sample_value;
    end
    mem_q_r <= mem[idx_r[ADDR_W-1:0]];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // accumulate samples; drop the ones beyond the store
      if (in_acc && store_ok) begin
        cnt_r <= cnt_inc;
        sum_r <= sum_r + {{(SUM_W-SAMPLE_W){in_ch.sample_value[SAMPLE_W-1]}},
                          in_ch.sample_value};
      end
      // clear the vector once its last result is loaded into the output register
      if (emit_load && last_idx) begin
        cnt_r <= '0;
        sum_r <= '0;
      end
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.last_sample) begin
      n_r     <= store_ok ? cnt_inc : cnt_r;
      idx_r   <= '0;
      pass2_r <= 1'b0;
      acc_r   <= '0;
    end
    case (state_r)
      ST_NX:  x_neg_r <= mem_q_r[SAMPLE_W-1];
      ST_D:   d_r     <= nx - sum_r;
      ST_ABS: begin
        d_neg_r <= d_r[SUM_W-1];
        mag_r   <= d_r[SUM_W-1] ? MAG_W'(SUM_W'(0) - d_r) : d_r[MAG_W-1:0];
      end
      ST_LH:  acc_r <= acc_r + Q_W'(mul_prod);
      ST_HH:  acc_r <= acc_r + (Q_W'(mul_prod) << (MUL_W + 1));
      ST_ACC: begin
        acc_r <= acc_r + (Q_W'(mul_prod) << (2 * MUL_W));
        idx_r <= idx_inc;
      end
      ST_SWAIT: begin
        if (!sqrt_busy) begin
          sdn_r   <= sqrt_root;
          pass2_r <= 1'b1;
          idx_r   <= '0;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          idx_r <= idx_inc;
        end
      end
      default: ;
    endcase
  end

  // Output register: load a finished item, hold it while the receiver stalls
  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_val_r  <= emit_val;
      out_flat_r <= sdn_zero;
      out_sat_r  <= emit_sat;
      out_last_r <= last_idx;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.normalized_value = out_val_r;
  assign out_ch.flat_vector      = out_flat_r;
  assign out_ch.saturated        = out_sat_r;
  assign out_ch.last_result      = out_last_r;

endmodule

@@ bench/tb_zscore_vector_normalizer_core.sv @@
`timescale 1ns / 1ps
// Self-checking bench for zscore_vector_normalizer_core: directed and random vectors.
// Depends on zvn_pkg, zvn_if and the normalizer RTL; needs no files or arguments.
module tb_zscore_vector_normalizer_core import zvn_pkg::*; ();

  // Allow a run many times slower than the slowest legal one.
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  // Cycles to watch for stray results after the last expected one.
  localparam int unsigned DRAIN_CYCLES = 300;

  // One normalized item as seen on the result channel.
  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                flat;
    logic                sat;
    logic                last_mark;
  } zscore_result_t;

  // Kinds of vector content for the random part.
  typedef enum int {
    MIX_UNIFORM,    // any 32-bit value
    MIX_CLUSTER,    // base plus a random offset masked by spread
    MIX_FLAT,       // every element equal
    MIX_TWO_LEVEL,  // two levels, base and base plus spread
    MIX_EXTREME     // range ends, zero and random values mixed
  } sample_mix_t;

  logic clk;
  logic rst_n;

  zvn_in_if  in_if ();
  zvn_out_if out_if ();

  zscore_vector_normalizer_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Predictor state: the current vector as the block should hold it.
  logic signed [SAMPLE_W-1:0] vec_store [MAX_ELEMENTS];
  int unsigned                vec_count;
  longint                     vec_sum;

  // Normalized items still owed by the block, oldest first.
  zscore_result_t pending_results [$];

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned samples_sent;
  int unsigned vectors_closed;
  int unsigned results_checked;
  int unsigned flat_results;
  int unsigned dropped_samples;
  bit          steady_tail;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d items still owed", $time, cycle_count,
               pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Absorb one accepted sample; on the closing sample compute mean and stddev over the
  // stored elements and queue one normalized item per element, in arrival order.
  task automatic absorb_sample(input logic [SAMPLE_W-1:0] raw, input logic closing);
    longint         n;
    longint         dev;
    logic [63:0]    mag;
    logic [63:0]    sdn;
    logic [63:0]    trial;
    logic [127:0]   sq_sum;
    logic [127:0]   var_n;
    logic [127:0]   quo;
    zscore_result_t item;
    // Drop samples beyond the store size; the last mark still counts.
    if (vec_count < MAX_ELEMENTS) begin
      vec_store[vec_count] = raw;
      vec_count++;
      vec_sum += longint'($signed(raw));
    end else begin
      dropped_samples++;
    end
    if (!closing) return;

    // Work in units of 2^-16 / n so every deviation stays an exact integer.
    n      = longint'(vec_count);
    sq_sum = '0;
    for (int i = 0; i < vec_count; i++) begin
      dev     = n * longint'(vec_store[i]) - vec_sum;
      mag     = (dev < 0) ? -dev : dev;
      sq_sum += 128'(mag) * 128'(mag);
    end
    // Take the floor square root of Q / n bit by bit: this is n * stddev.
    var_n = sq_sum / 128'(vec_count);
    sdn   = '0;
    for (int b = 63; b >= 0; b--) begin
      trial = sdn | (64'd1 << b);
      if (128'(trial) * 128'(trial) <= var_n) sdn = trial;
    end

    for (int i = 0; i < vec_count; i++) begin
      item           = '0;
      item.flat      = (sdn == 0);
      item.last_mark = (i == vec_count - 1);
      if (sdn != 0) begin
        dev = n * longint'(vec_store[i]) - vec_sum;
        mag = (dev < 0) ? -dev : dev;
        // Round to nearest, ties away from zero, on the magnitude.
        quo = ((128'(mag) << FRAC_W) + 128'(sdn >> 1)) / 128'(sdn);
        if (dev >= 0) begin
          if (quo > 128'(POS_MAX)) begin
            item.value = POS_MAX;
            item.sat   = 1'b1;
          end else begin
            item.value = quo[SAMPLE_W-1:0];
          end
        end else begin
          if (quo > 128'(NEG_MIN)) begin
            item.value = NEG_MIN;
            item.sat   = 1'b1;
          end else begin
            item.value = -quo[SAMPLE_W-1:0];
          end
        end
      end
      pending_results = {pending_results, item};
    end
    vectors_closed++;
    vec_count = 0;
    vec_sum   = 0;
  endtask

  // Drive one sample and hold it until accepted. Valid stays high between back-to-back
  // items and is lowered only for an idle burst, so it gets one assignment per edge.
  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic closing);
    if (!steady_tail && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.sample_value <= value;
    in_if.last_sample  <= closing;
    do @(posedge clk); while (!in_if.ready);
    absorb_sample(value, closing);
    samples_sent++;
  endtask

  task automatic send_vector(input logic [SAMPLE_W-1:0] vals [$]);
    foreach (vals[i]) send_sample(vals[i], i == vals.size() - 1);
  endtask

  function automatic logic [SAMPLE_W-1:0] draw_sample(input sample_mix_t mix,
                                                      input logic [SAMPLE_W-1:0] base,
                                                      input logic [SAMPLE_W-1:0] spread);
    case (mix)
      MIX_CLUSTER:   return base + ($urandom() & spread);
      MIX_FLAT:      return base;
      MIX_TWO_LEVEL: return $urandom_range(0, 1) ? base : base + spread;
      MIX_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return POS_MAX;
          1:       return NEG_MIN;
          2:       return '0;
          default: return $urandom();
        endcase
      end
      default:       return $urandom();
    endcase
  endfunction

  // Send one vector of the given length with a random kind of content.
  task automatic send_random_vector(input int unsigned len);
    logic [SAMPLE_W-1:0] vals [$];
    logic [SAMPLE_W-1:0] base;
    logic [SAMPLE_W-1:0] spread;
    sample_mix_t         mix;
    int unsigned         spread_bits;
    mix         = sample_mix_t'($urandom_range(0, 4));
    base        = $urandom();
    spread_bits = $urandom_range(0, SAMPLE_W - 1);
    spread      = (spread_bits == 0) ? '0 : ({SAMPLE_W{1'b1}} >> (SAMPLE_W - spread_bits));
    repeat (len) vals = {vals, draw_sample(mix, base, spread)};
    send_vector(vals);
  endtask

  // Result side: pace ready in random stall bursts, none once the steady tail starts.
  initial begin : result_pacing
    out_if.ready <= 1'b0;
    forever begin
      if (!steady_tail && $urandom_range(0, 2) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // Compare every accepted result with the oldest owed item.
  always @(posedge clk) begin : result_check
    zscore_result_t got;
    zscore_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.normalized_value, out_if.flat_vector, out_if.saturated,
              out_if.last_result};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item value=%h flat=%b sat=%b last=%b", $time,
                 got.value, got.flat, got.sat, got.last_mark);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.flat) flat_results++;
        if (got !== want) begin
          $display("%0t: mismatch expected value=%h flat=%b sat=%b last=%b,", $time,
                   want.value, want.flat, want.sat, want.last_mark);
          $display("  actual value=%h flat=%b sat=%b last=%b",
                   got.value, got.flat, got.sat, got.last_mark);
          mismatch_count++;
        end
      end
    end
  end

  // A one-element vector has zero deviation: one flat item.
  task automatic test_single_element();
    logic [SAMPLE_W-1:0] vals [$];
    vals = '{POS_MAX};
    send_vector(vals);
  endtask

  // Two-element vectors at the range ends and one LSB apart: results of +/-1.0.
  task automatic test_extreme_pairs();
    logic [SAMPLE_W-1:0] vals [$];
    vals = '{NEG_MIN, POS_MAX};
    send_vector(vals);
    vals = '{32'h0000_0000, 32'h0000_0001};
    send_vector(vals);
    vals = '{32'hFFFF_FFFF, 32'h0000_0000};
    send_vector(vals);
  endtask

  // Equal elements give zero deviation: every item zero and flagged flat.
  task automatic test_flat_vectors();
    logic [SAMPLE_W-1:0] vals [$];
    vals = '{NEG_MIN, NEG_MIN, NEG_MIN};
    send_vector(vals);
    vals = '{32'h0000_0000, 32'h0000_0000};
    send_vector(vals);
  endtask

  // Mix range ends, zero, +/-1 LSB and +/-1.0 within one vector.
  task automatic test_mixed_extremes();
    logic [SAMPLE_W-1:0] vals [$];
    vals = '{POS_MAX, NEG_MIN, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
             32'h0001_0000, 32'hFFFF_0000, POS_MAX};
    send_vector(vals);
  endtask

  // Fill the store exactly, then overrun it so the closing sample itself is dropped.
  task automatic test_store_full();
    send_random_vector(MAX_ELEMENTS);
    send_random_vector(MAX_ELEMENTS + 2);
  endtask

  // Random vectors, mostly short, some long, with random idling on both sides.
  task automatic test_random_vectors(input int unsigned item_goal);
    int unsigned stop_at;
    int unsigned len;
    stop_at = samples_sent + item_goal;
    while (samples_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: len = $urandom_range(1, 8);
        7, 8:                len = $urandom_range(9, 24);
        default:             len = $urandom_range(25, MAX_ELEMENTS);
      endcase
      send_random_vector(len);
    end
  endtask

  // Full rate on both sides to close the run.
  task automatic test_steady_stream();
    steady_tail = 1'b1;
    send_random_vector($urandom_range(8, 16));
    send_random_vector($urandom_range(1, 4));
    send_random_vector($urandom_range(8, 16));
  endtask

  initial begin
    // Drive every input to a known value before the first edge.
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.sample_value <= '0;
    in_if.last_sample  <= 1'b0;
    samples_sent       = 0;
    vectors_closed     = 0;
    dropped_samples    = 0;
    steady_tail        = 1'b0;
    vec_count          = 0;
    vec_sum            = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_single_element();
    test_extreme_pairs();
    test_flat_vectors();
    test_mixed_extremes();
    test_store_full();
    test_random_vectors(70);
    test_steady_stream();

    // Drop valid and wait out every owed item, then watch for strays.
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d samples in %0d vectors (%0d dropped past a full store),",
             samples_sent, vectors_closed, dropped_samples);
    $display("checking %0d normalized items, %0d of them flat, in %0d cycles.",
             results_checked, flat_results, cycle_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
